// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the wide integer ALU.
// Self-contained; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define WIA_ASSERT_IMPL(lbl, clk_sig, rst_n_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |-> (cons)) \
		else $error("wia assertion failed");

// Next-cycle implication, off while reset is asserted.
`define WIA_ASSERT_NEXT(lbl, clk_sig, rst_n_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |=> (cons)) \
		else $error("wia assertion failed");

`endif

// ===== hdl/wia_pkg.sv =====
// Types and constants of the wide integer ALU.
// No dependencies; imported by every module of the block.
package wia_pkg;

	localparam int WORD_BITS  = 128;
	localparam int FIELD_BITS = 64;
	localparam int PAIR_BITS  = 2 * FIELD_BITS;
	localparam int OP_BITS    = 3;

	typedef logic [WORD_BITS-1:0]  word_t;
	typedef logic [PAIR_BITS-1:0]  pair_t;
	typedef logic [FIELD_BITS-1:0] field_t;

	typedef enum logic [OP_BITS-1:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_AND = 3'd2,
		OP_OR  = 3'd3,
		OP_XOR = 3'd4,
		OP_NOT = 3'd5,
		OP_DIV = 3'd6,
		OP_MOD = 3'd7
	} op_t;

	typedef struct packed {
		logic [OP_BITS-1:0] req_type;
		field_t             a_low;
		field_t             a_high;
		field_t             b_low;
		field_t             b_high;
	} req_t;

	typedef struct packed {
		field_t result_low;
		field_t result_high;
	} res_t;

	// One slot of the divider pipeline. For non-divide operations nq holds
	// the finished result and the slot passes through untouched.
	typedef struct packed {
		logic  valid;
		op_t   op;
		logic  is_div;
		word_t rem;
		word_t nq;
		word_t div;
	} pipe_t;

endpackage

// ===== hdl/wia_div_stage.sv =====
// One restoring-division step with its pipeline register.
// Depends on wia_pkg.
module wia_div_stage
	import wia_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  pipe_t pipe_in,
	output pipe_t pipe_s1
);

	logic                 carry;
	word_t                shifted;
	logic [WORD_BITS:0]   diff;
	logic                 borrow;
	logic                 take;
	pipe_t                nxt;

	always_comb begin
		carry   = pipe_in.rem[WORD_BITS-1];
		// shift the next dividend bit in from the top of nq
		shifted = {pipe_in.rem[WORD_BITS-2:0], pipe_in.nq[WORD_BITS-1]};
		{borrow, diff} = {1'b0, carry, shifted} - {2'b00, pipe_in.div};
		take    = !borrow;
		nxt     = pipe_in;
		if (pipe_in.is_div) begin
			nxt.rem = take ? diff[WORD_BITS-1:0] : shifted;
			nxt.nq  = {pipe_in.nq[WORD_BITS-2:0], take};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_s1 <= '0;
		end else begin
			pipe_s1 <= nxt;
		end
	end

endmodule

// ===== hdl/wide_integer_alu_unit.sv =====
// Results strobe on done after valid_s1, pipe_s2, each division step and done_q.
// Throughput: one operation per cycle; the depth is set by the 128 restoring
// division steps, one step per pipeline stage, which every operation passes.
// busy stays low: the pipeline never stalls, since results cannot be held off.
// Reset clears all valid bits; operations in flight are dropped.
// Top level of the wide integer ALU. Depends on wia_pkg, wia_div_stage and
// assert_macros.svh.
`include "assert_macros.svh"

module wide_integer_alu_unit
	import wia_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output res_t result
);

	logic  valid_s1;
	req_t  req_s1;
	pipe_t pipe_s2;
	pipe_t pipe [0:WORD_BITS];

	word_t a_w;
	word_t b_w;
	word_t alu_res;
	op_t   op_w;
	pipe_t init;

	word_t res_w;
	pair_t res_pair;
	logic  done_q;
	res_t  result_q;

	assign busy = 1'b0;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		req_s1 <= req;
	end

	// Logic operations and divider set-up
	always_comb begin
		a_w  = word_t'({req_s1.a_high, req_s1.a_low});
		b_w  = word_t'({req_s1.b_high, req_s1.b_low});
		op_w = op_t'(req_s1.req_type);
		case (op_w)
			OP_ADD:  alu_res = a_w + b_w;
			OP_SUB:  alu_res = a_w - b_w;
			OP_AND:  alu_res = a_w & b_w;
			OP_OR:   alu_res = a_w | b_w;
			OP_XOR:  alu_res = a_w ^ b_w;
			OP_NOT:  alu_res = ~a_w;
			default: alu_res = a_w;
		endcase
		init.valid  = valid_s1;
		init.op     = op_w;
		init.is_div = (op_w == OP_DIV) || (op_w == OP_MOD);
		init.rem    = '0;
		init.nq     = alu_res;
		init.div    = b_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_s2 <= '0;
		end else begin
			pipe_s2 <= init;
		end
	end

	assign pipe[0] = pipe_s2;

	// Division steps
	for (genvar k = 0; k < WORD_BITS; k++) begin : g_step
		wia_div_stage u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.pipe_in (pipe[k]),
			.pipe_s1 (pipe[k+1])
		);
	end

	// Output register
	always_comb begin
		res_w    = (pipe[WORD_BITS].op == OP_MOD) ? pipe[WORD_BITS].rem : pipe[WORD_BITS].nq;
		res_pair = pair_t'(res_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= pipe[WORD_BITS].valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q.result_low  <= res_pair[FIELD_BITS-1:0];
		result_q.result_high <= res_pair[PAIR_BITS-1:FIELD_BITS];
	end

	assign done   = done_q;
	assign result = result_q;

	`WIA_ASSERT_IMPL(a_rem_below_div, clk, arst_n,
		pipe[WORD_BITS].valid && pipe[WORD_BITS].is_div && (pipe[WORD_BITS].div != '0),
		pipe[WORD_BITS].rem < pipe[WORD_BITS].div)
	`WIA_ASSERT_IMPL(a_div_zero_ones, clk, arst_n,
		pipe[WORD_BITS].valid && pipe[WORD_BITS].is_div && (pipe[WORD_BITS].div == '0),
		pipe[WORD_BITS].nq == '1)
	`WIA_ASSERT_NEXT(a_transfer_enters, clk, arst_n, start && !busy, valid_s1)

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for the wide integer ALU: directed corner cases, then random traffic.
// Depends on wia_pkg and wide_integer_alu_unit; results are checked against a local predictor.
`timescale 1ns / 100ps

module tb_top;
	import wia_pkg::*;

	localparam int N_RANDOM    = 1150;
	localparam int SETTLE      = WORD_BITS + 12;
	localparam int STALL_LIMIT = 2000;

	typedef struct {
		req_t req;
		int   gap;
		bit   drain;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic done;
	res_t result;

	stim_t pending_ops[$];
	res_t  due_results[$];
	int    n_items = 0;
	int    n_sent = 0;
	int    n_done = 0;
	int    n_zero_div = 0;
	int    errors = 0;
	int    quiet = 0;

	wide_integer_alu_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.result(result)
	);

	always #10 clk = ~clk;

	function automatic res_t alu_result(req_t r);
		word_t                a;
		word_t                b;
		word_t                y;
		word_t                quo;
		logic [WORD_BITS:0]   part;
		res_t                 res;
		a = {r.a_high, r.a_low};
		b = {r.b_high, r.b_low};
		y = '0;
		case (op_t'(r.req_type))
			OP_ADD: y = a + b;
			OP_SUB: y = a - b;
			OP_AND: y = a & b;
			OP_OR:  y = a | b;
			OP_XOR: y = a ^ b;
			OP_NOT: y = ~a;
			OP_DIV, OP_MOD: begin
				// restoring division with one carry bit above the partial remainder
				part = '0;
				quo = '0;
				for (int i = WORD_BITS - 1; i >= 0; i--) begin
					part = {part[WORD_BITS-1:0], a[i]};
					if (part >= {1'b0, b}) begin
						part = part - {1'b0, b};
						quo[i] = 1'b1;
					end
				end
				y = (op_t'(r.req_type) == OP_DIV) ? quo : part[WORD_BITS-1:0];
			end
			default: y = '0;
		endcase
		res.result_low = y[FIELD_BITS-1:0];
		res.result_high = y[WORD_BITS-1:FIELD_BITS];
		return res;
	endfunction

	function automatic int pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 4);
		return $urandom_range(20, 80);
	endfunction

	function automatic word_t pick_operand();
		word_t w;
		w = {$urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(0, 11))
			0: w = '0;
			1: w = '1;
			2: w = word_t'(1) << $urandom_range(0, WORD_BITS - 1);
			3: w = w >> $urandom_range(1, WORD_BITS - 1);
			4: w = w >> $urandom_range(WORD_BITS - 32, WORD_BITS - 1);
			5: w = ~(word_t'(1) << $urandom_range(0, WORD_BITS - 1));
			6: w = {{FIELD_BITS{1'b0}}, w[FIELD_BITS-1:0]};
			7: w = {w[WORD_BITS-1:FIELD_BITS], {FIELD_BITS{1'b0}}};
			default: ;
		endcase
		return w;
	endfunction

	task automatic queue_op(op_t op, word_t a, word_t b, int gap);
		stim_t s;
		s.req.req_type = op;
		s.req.a_low = a[FIELD_BITS-1:0];
		s.req.a_high = a[WORD_BITS-1:FIELD_BITS];
		s.req.b_low = b[FIELD_BITS-1:0];
		s.req.b_high = b[WORD_BITS-1:FIELD_BITS];
		s.gap = gap;
		s.drain = 1'b0;
		if ((op == OP_DIV || op == OP_MOD) && b == '0)
			n_zero_div++;
		pending_ops.insert(pending_ops.size(), s);
		n_items++;
	endtask

	// Driver: hold start while busy, else send the next item when its gap and any drain are over.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				n_sent <= n_sent + 1;
			if (start && busy) begin
			end else if (pending_ops.size() == 0) begin
				start <= 1'b0;
			end else if (pending_ops[0].gap > 0) begin
				start <= 1'b0;
				pending_ops[0].gap--;
			end else if (pending_ops[0].drain && (start || n_done != n_sent)) begin
				start <= 1'b0;
			end else begin
				start <= 1'b1;
				req <= pending_ops[0].req;
				pending_ops.pop_front();
			end
		end
	end

	// Monitor: predict on each input transfer, check each strobed result against the oldest.
	always @(posedge clk) begin : monitor
		res_t want;
		if (arst_n) begin
			if (start && !busy)
				due_results.insert(due_results.size(), alu_result(req));
			if (done) begin
				n_done <= n_done + 1;
				if (due_results.size() == 0) begin
					$error("result %h with no transfer outstanding", result);
					errors++;
				end else begin
					want = due_results.pop_front();
					if (result.result_low !== want.result_low) begin
						$error("result_low: expected %h, got %h",
							want.result_low, result.result_low);
						errors++;
					end
					if (result.result_high !== want.result_high) begin
						$error("result_high: expected %h, got %h",
							want.result_high, result.result_high);
						errors++;
					end
				end
			end
		end
	end

	// Watchdog: give up after a long run of cycles with no transfer on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= STALL_LIMIT) begin
				$display("tb_top failed");
				$finish;
			end
		end
	end

	initial begin
		word_t ones;
		word_t r1;
		word_t r2;
		ones = '1;
		r1 = {$urandom, $urandom, $urandom, $urandom};
		r2 = {$urandom, $urandom, $urandom, $urandom};

		queue_op(OP_ADD, '0, '0, 0);
		queue_op(OP_ADD, ones, word_t'(1), 0);
		queue_op(OP_ADD, {{FIELD_BITS{1'b0}}, {FIELD_BITS{1'b1}}}, word_t'(1), 1);
		queue_op(OP_SUB, '0, word_t'(1), 0);
		queue_op(OP_SUB, r1, r1, 0);
		queue_op(OP_SUB, word_t'(1) << FIELD_BITS, word_t'(1), 2);
		queue_op(OP_AND, ones, r2, 0);
		queue_op(OP_OR, '0, r1, 0);
		queue_op(OP_XOR, r1, r2, 0);
		queue_op(OP_XOR, ones, ones, 0);
		queue_op(OP_NOT, '0, ones, 0);
		queue_op(OP_NOT, r2, r1, 3);
		queue_op(OP_DIV, r1, '0, 0);
		queue_op(OP_MOD, r2, '0, 0);
		queue_op(OP_DIV, '0, '0, 0);
		queue_op(OP_DIV, ones, ones, 0);
		queue_op(OP_MOD, ones, word_t'(1), 0);
		queue_op(OP_DIV, ones, word_t'(1), 0);
		queue_op(OP_DIV, r1 >> 64, r2 | (word_t'(1) << (WORD_BITS - 1)), 0);
		queue_op(OP_MOD, r1 >> 64, r2 | (word_t'(1) << (WORD_BITS - 1)), 0);
		queue_op(OP_DIV, r1, r2 >> 70, 1);
		queue_op(OP_MOD, word_t'(1) << (WORD_BITS - 1), word_t'(3), 0);
		queue_op(OP_MOD, '0, r2, 0);
		queue_op(OP_DIV, ones, word_t'(1) << (WORD_BITS - 1), 0);

		for (int i = 0; i < N_RANDOM; i++) begin
			// alternate stretches of back-to-back traffic with randomly gapped traffic
			queue_op(op_t'($urandom_range(0, 7)), pick_operand(), pick_operand(),
				((i / 64) % 4 == 1) ? 0 : pick_gap());
			// drain the pipeline now and then before the next transfer
			if (i % 300 == 0)
				pending_ops[$].drain = 1'b1;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (n_sent != n_items || n_done != n_sent);
		repeat (SETTLE) @(posedge clk);

		if (due_results.size() != 0) begin
			$error("%0d results never arrived", due_results.size());
			errors++;
		end
		$display("Covered %0d transfers over all eight operations, corner operands included,",
			n_items);
		$display("with %0d divide or modulo by zero; %0d mismatches seen.", n_zero_div, errors);
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
